@@ sv/bfa_pkg.sv @@
// Shared types and constants for the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int FRAME_W        = 20;
  localparam int OP_W           = 2;
  localparam int NUM_FRAMES_DEF = 1024;
  localparam int WORD_BITS_DEF  = 32;
  localparam int S_TDATA_W      = 24;
  localparam int M_TDATA_W      = 24;

  // Operation codes; any code with the high bit set is a query.
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam int              OP_QUERY_BIT = 1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DOUBLE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_DIV,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    status_e            status;
    logic               allocated;
  } res_t;

endpackage

@@ sv/bfa_bitmap_mem.sv @@
// Bitmap storage: one write port and one registered read port.
`timescale 1ns / 1ps

module bfa_bitmap_mem #(
  parameter int WORDS     = bfa_pkg::NUM_FRAMES_DEF / bfa_pkg::WORD_BITS_DEF,
  parameter int WORD_BITS = bfa_pkg::WORD_BITS_DEF,
  parameter int AW        = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [WORD_BITS-1:0] wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [WORD_BITS-1:0] rd_data_o
);

  logic [WORD_BITS-1:0] mem_q [WORDS];
  logic [WORD_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/bfa_engine.sv @@
// Sequencer and shared datapath: clearing pass, first-fit scan, index split.
`timescale 1ns / 1ps

module bfa_engine #(
  parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
  parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF,
  parameter int WORDS      = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS,
  parameter int AW         = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bfa_pkg::FRAME_W-1:0]   base_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bfa_pkg::OP_W-1:0]      op_i,
  input  logic [bfa_pkg::FRAME_W-1:0]   frame_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output bfa_pkg::res_t                 res_o,
  output logic                          mem_wr_en_o,
  output logic [AW-1:0]                 mem_wr_addr_o,
  output logic [WORD_BITS-1:0]          mem_wr_data_o,
  output logic                          mem_rd_en_o,
  output logic [AW-1:0]                 mem_rd_addr_o,
  input  logic [WORD_BITS-1:0]          mem_rd_data_i
);

  import bfa_pkg::*;

  localparam int CW        = $clog2(WORDS + 1);
  localparam int IW        = $clog2(NUM_FRAMES);
  localparam int IXW       = $clog2(NUM_FRAMES + WORD_BITS);
  localparam int RMW       = $clog2(WORD_BITS);
  localparam int LAST_BITS = NUM_FRAMES - (WORDS - 1) * WORD_BITS;
  // Reciprocal of the word size, scaled so that the quotient is exact for every index.
  localparam int QSH       = IW + RMW;
  localparam int MW        = IW + 2;
  localparam int PW        = IW + MW;
  localparam logic [MW-1:0] RECIP = MW'(((1 << QSH) + WORD_BITS - 1) / WORD_BITS);
  // Bits of the last word that lie past the managed window read as used.
  localparam logic [WORD_BITS-1:0] TAIL_MASK = {WORD_BITS{1'b1}} << LAST_BITS;

  state_e             state_q, state_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [RMW-1:0]     rem_q, rem_d;
  logic [CW-1:0]      iss_q, iss_d;
  logic [IXW-1:0]     iss_base_q, iss_base_d;
  logic [AW-1:0]      chk_q, chk_d;
  logic [IXW-1:0]     chk_base_q, chk_base_d;
  logic               pend_q, pend_d;
  res_t               res_q, res_d;

  logic [FRAME_W:0]     diff;
  logic                 in_win;
  logic                 is_query;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] low_free;
  logic                 has_free;
  logic [RMW-1:0]       bit_idx;
  logic [PW-1:0]        prod;
  logic                 bit_set;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      iss_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    idx_q      <= idx_d;
    rem_q      <= rem_d;
    iss_base_q <= iss_base_d;
    chk_q      <= chk_d;
    chk_base_q <= chk_base_d;
    res_q      <= res_d;
  end

  // Window check and first-zero search of the word on the read port.
  always_comb begin
    diff     = {1'b0, frame_i} - {1'b0, base_i};
    in_win   = !diff[FRAME_W] && (diff[FRAME_W-1:0] < FRAME_W'(NUM_FRAMES));
    is_query = op_i[OP_QUERY_BIT];

    free_bits = ~(mem_rd_data_i | ((chk_q == AW'(WORDS - 1)) ? TAIL_MASK : '0));
    low_free  = free_bits & (~free_bits + WORD_BITS'(1));
    has_free  = |free_bits;
    bit_idx   = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (low_free[b]) begin
        bit_idx = bit_idx | RMW'(b);
      end
    end

    prod    = PW'(idx_q) * PW'(RECIP);
    bit_set = mem_rd_data_i[rem_q];
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    idx_d      = idx_q;
    rem_d      = rem_q;
    iss_d      = iss_q;
    iss_base_d = iss_base_q;
    chk_d      = chk_q;
    chk_base_d = chk_base_q;
    pend_d     = pend_q;
    res_d      = res_q;

    in_ready_o    = 1'b0;
    res_valid_o   = 1'b0;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = chk_q;
    mem_wr_data_o = '0;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = iss_q[AW-1:0];

    case (state_q)
      S_CLEAR: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = iss_q[AW-1:0];
        if (iss_q == CW'(WORDS - 1)) begin
          iss_d   = '0;
          state_d = S_IDLE;
        end else begin
          iss_d = iss_q + CW'(1);
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d = op_i;
          if (op_i == OP_ALLOC) begin
            iss_d      = '0;
            iss_base_d = '0;
            pend_d     = 1'b0;
            state_d    = S_SCAN;
          end else if (in_win) begin
            idx_d   = diff[IW-1:0];
            state_d = S_DIV;
          end else begin
            res_d.frame     = '0;
            res_d.status    = is_query ? ST_OK : ST_RANGE;
            res_d.allocated = 1'b0;
            state_d         = S_DONE;
          end
        end
      end

      // One word is issued per cycle while the previous one is examined.
      S_SCAN: begin
        if (pend_q && has_free) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = chk_q;
          mem_wr_data_o = mem_rd_data_i | low_free;
          idx_d         = IW'(chk_base_q + IXW'(bit_idx));
          pend_d        = 1'b0;
          state_d       = S_ALLOC;
        end else if (pend_q && (chk_q == AW'(WORDS - 1))) begin
          res_d.frame     = '0;
          res_d.status    = ST_FULL;
          res_d.allocated = 1'b0;
          pend_d          = 1'b0;
          state_d         = S_DONE;
        end else if (iss_q != CW'(WORDS)) begin
          mem_rd_en_o = 1'b1;
          pend_d      = 1'b1;
          chk_d       = iss_q[AW-1:0];
          chk_base_d  = iss_base_q;
          iss_d       = iss_q + CW'(1);
          iss_base_d  = iss_base_q + IXW'(WORD_BITS);
        end else begin
          pend_d = 1'b0;
        end
      end

      S_ALLOC: begin
        res_d.frame     = base_i + FRAME_W'(idx_q);
        res_d.status    = ST_OK;
        res_d.allocated = 1'b0;
        state_d         = S_DONE;
      end

      // The word of the index comes from a multiply by the scaled reciprocal.
      S_DIV: begin
        chk_d   = prod[QSH +: AW];
        state_d = S_READ;
      end

      // The bit within the word is what is left after the word's first index.
      S_READ: begin
        mem_rd_en_o   = 1'b1;
        mem_rd_addr_o = chk_q;
        rem_d         = RMW'(IXW'(idx_q) - IXW'(chk_q) * IXW'(WORD_BITS));
        state_d       = S_CHECK;
      end

      S_CHECK: begin
        res_d.frame     = '0;
        res_d.status    = ST_OK;
        res_d.allocated = 1'b0;
        if (op_q[OP_QUERY_BIT]) begin
          res_d.allocated = bit_set;
        end else if (!bit_set) begin
          res_d.status = ST_DOUBLE;
        end else begin
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = chk_q;
          mem_wr_data_o = mem_rd_data_i & ~(WORD_BITS'(1) << rem_q);
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

@@ sv/bitmap_frame_allocator_unit.sv @@
// Top level of the bitmap first-fit page frame allocator.
//
// Usage: requests enter on the s_axis channel, one item per operation
// (allocate, free, query); every request yields exactly one result item on
// the m_axis channel. The frame base register is written through cfg_we_i
// and cfg_wdata_i; the user must write it only while the block is idle,
// which the block does not enforce itself; it resets to 0. An allocate
// scans the bitmap from word 0 up for the lowest free frame, one bitmap
// word per cycle through the single memory read port, and answers full
// after the last word. A free or query in the window finds the word by a
// reciprocal multiply, reads it, then checks and updates the bit; one
// outside the window skips these steps. One request is in work at a time.
// Reset: the bitmap is cleared by a pass that writes one word per cycle
// into all WORDS = ceil(NUM_FRAMES / WORD_BITS) words, tready held low.
// Stalls: a result is held in an output register until m_axis_tready; the
// next request is still taken meanwhile, and its own result waits in the
// engine until the output register frees up.
`timescale 1ns / 1ps

module bitmap_frame_allocator_unit #(
  parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
  parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bfa_pkg::FRAME_W-1:0]    cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // operation [1:0], frame_number [21:2], zero [23:22]
  input  logic [bfa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_frame [19:0], status [21:20], allocated [22], zero [23]
  output logic [bfa_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  import bfa_pkg::*;

  localparam int WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [FRAME_W-1:0]   base_q;
  logic                 out_vld_q;
  res_t                 out_q;
  res_t                 res;
  logic                 res_valid;
  logic                 res_ready;
  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;
  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  bfa_engine #(
    .NUM_FRAMES (NUM_FRAMES),
    .WORD_BITS  (WORD_BITS),
    .WORDS      (WORDS),
    .AW         (AW)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .base_i        (base_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (s_axis_tdata[OP_W-1:0]),
    .frame_i       (s_axis_tdata[OP_W+FRAME_W-1:OP_W]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  bfa_bitmap_mem #(
    .WORDS     (WORDS),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // Output register between the engine and the result channel.
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.allocated, out_q.status, out_q.frame};

endmodule

@@ sv/bfa_checker.sv @@
// Port-level checks for the frame allocator, bound to the top level.
`timescale 1ns / 1ps

module bfa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bfa_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  import bfa_pkg::*;

  // A held result keeps its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // Only one request is in work: the block is busy right after taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in work");

  // A new result only shows up when the engine has been busy finishing one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a request in work");

  // A query hit or a nonzero frame always comes with an ok status, and never both at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[22] || (m_axis_tdata[FRAME_W-1:0] != '0))
      |-> (m_axis_tdata[21:20] == ST_OK) && !(m_axis_tdata[22] &&
           (m_axis_tdata[FRAME_W-1:0] != '0)))
    else $error("inconsistent result fields");

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ bench/tb_bitmap_frame_allocator_unit.sv @@
// Self-checking testbench for the bitmap frame allocator: directed, fill-to-full and random runs.
`timescale 1ns / 1ps

module tb_bitmap_frame_allocator_unit;
  import bfa_pkg::*;

  localparam int NUM_FRAMES = NUM_FRAMES_DEF;
  localparam int WORD_BITS = WORD_BITS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_PRINTED = 30;

  // Query codes; the block looks only at the high bit, so both must act alike.
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY_HI = 2'd3;

  localparam logic [FRAME_W-1:0] BASE_TOP = 20'd1047552;
  localparam logic [FRAME_W-1:0] FRAME_TOP = 20'hFFFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [FRAME_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Shadow copy of the allocator state.
  logic [NUM_FRAMES-1:0] shadow_used = '0;
  logic [FRAME_W-1:0] shadow_base = '0;
  int shadow_used_count = 0;

  res_t pending_results[$];
  int err_count = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit req_live = 1'b0;

  bitmap_frame_allocator_unit #(
    .NUM_FRAMES(NUM_FRAMES),
    .WORD_BITS (WORD_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 20);
    end
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("mismatch: %s", msg);
  endtask

  // Applies one request to the shadow state and returns the answer it must give.
  function automatic res_t predict_request(input logic [OP_W-1:0] op,
                                           input logic [FRAME_W-1:0] frame);
    res_t r;
    int unsigned offset;
    bit in_win;
    int slot;
    r.frame = '0;
    r.status = ST_OK;
    r.allocated = 1'b0;
    offset = int'(frame) - int'(shadow_base);
    in_win = (frame >= shadow_base) && (offset < NUM_FRAMES);
    slot = -1;
    if (op[OP_QUERY_BIT]) begin
      r.allocated = in_win && shadow_used[offset];
    end else if (op == OP_FREE) begin
      if (!in_win) begin
        r.status = ST_RANGE;
      end else if (!shadow_used[offset]) begin
        r.status = ST_DOUBLE;
      end else begin
        shadow_used[offset] = 1'b0;
        shadow_used_count--;
      end
    end else begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (!shadow_used[i]) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) begin
        r.status = ST_FULL;
      end else begin
        shadow_used[slot] = 1'b1;
        shadow_used_count++;
        r.frame = shadow_base + FRAME_W'(slot);
      end
    end
    return r;
  endfunction

  // Mostly frames inside the window (often ones in use), plus window edges and noise.
  function automatic logic [FRAME_W-1:0] pick_frame();
    int unsigned roll;
    int unsigned idx;
    int unsigned spot;
    roll = $urandom_range(0, 99);
    idx = $urandom_range(0, NUM_FRAMES - 1);
    if (roll < 55) begin
      spot = idx;
      if (roll < 30) begin
        for (int k = 0; k < NUM_FRAMES; k++) begin
          if (shadow_used[(idx + k) % NUM_FRAMES]) begin
            spot = (idx + k) % NUM_FRAMES;
            break;
          end
        end
      end
      return shadow_base + FRAME_W'(spot);
    end
    if (roll < 75) return FRAME_W'($urandom);
    if (roll < 85) begin
      return $urandom_range(0, 1) ? shadow_base - 20'd1 : shadow_base + FRAME_W'(NUM_FRAMES);
    end
    return $urandom_range(0, 1) ? shadow_base : shadow_base + FRAME_W'(NUM_FRAMES - 1);
  endfunction

  task automatic drop_valid();
    if (req_live) begin
      s_axis_tvalid <= 1'b0;
      req_live = 1'b0;
    end
  endtask

  // Valid stays high after the handshake so back-to-back items need no toggle.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] frame);
    while (!calm && $urandom_range(0, 99) < 20) begin
      drop_valid();
      @(posedge clk_i);
    end
    s_axis_tdata <= {2'b00, frame, op};
    if (!req_live) begin
      s_axis_tvalid <= 1'b1;
      req_live = 1'b1;
    end
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_request(op, frame));
  endtask

  task automatic wait_results_done();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [FRAME_W-1:0] value);
    wait_results_done();
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    shadow_base = value;
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result item 0x%06h with nothing expected", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[19:0] !== want.frame) begin
          report_mismatch($sformatf("result_frame 0x%05h, expected 0x%05h",
                                    m_axis_tdata[19:0], want.frame));
        end
        if (m_axis_tdata[21:20] !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    m_axis_tdata[21:20], want.status));
        end
        if (m_axis_tdata[22] !== want.allocated) begin
          report_mismatch($sformatf("allocated %0b, expected %0b",
                                    m_axis_tdata[22], want.allocated));
        end
      end
    end
  end

  task automatic test_directed_cases();
    // Base 0 after reset: double free on an empty map, lowest-first reuse, window edges.
    send_request(OP_QUERY, 20'd0);
    send_request(OP_FREE, 20'd0);
    send_request(OP_ALLOC, FRAME_TOP);
    send_request(OP_ALLOC, 20'd0);
    send_request(OP_QUERY, 20'd0);
    send_request(OP_QUERY_HI, 20'd1);
    send_request(OP_FREE, 20'd0);
    send_request(OP_FREE, 20'd0);
    send_request(OP_ALLOC, 20'd0);
    send_request(OP_FREE, FRAME_W'(NUM_FRAMES));
    send_request(OP_QUERY, FRAME_W'(NUM_FRAMES));
    send_request(OP_FREE, FRAME_TOP);
    // Highest base: the window ends exactly at the top frame number.
    write_base(BASE_TOP);
    send_request(OP_ALLOC, 20'd0);
    send_request(OP_QUERY, BASE_TOP);
    send_request(OP_QUERY, BASE_TOP - 20'd1);
    send_request(OP_FREE, BASE_TOP - 20'd1);
    send_request(OP_FREE, FRAME_TOP);
    send_request(OP_QUERY, FRAME_TOP);
    send_request(OP_FREE, BASE_TOP + 20'd1);
    send_request(OP_ALLOC, FRAME_TOP);
    send_request(OP_QUERY_HI, FRAME_TOP);
  endtask

  task automatic test_fill_to_full();
    logic [FRAME_W-1:0] base;
    base = FRAME_W'($urandom_range(1, BASE_TOP - 1));
    write_base(base);
    // No idling on either side for this whole stretch.
    calm = 1'b1;
    while (shadow_used_count < NUM_FRAMES) send_request(OP_ALLOC, FRAME_W'($urandom));
    repeat (3) send_request(OP_ALLOC, FRAME_W'($urandom));
    send_request(OP_QUERY, base + FRAME_W'(NUM_FRAMES - 1));
    send_request(OP_FREE, base + FRAME_W'(NUM_FRAMES - 1));
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, base + 20'd512);
    send_request(OP_FREE, base + 20'd512);
    send_request(OP_QUERY_HI, base + 20'd512);
    calm = 1'b0;
  endtask

  task automatic test_random_mix(input logic [FRAME_W-1:0] base, input int alloc_pct,
                                 input int count);
    logic [OP_W-1:0] op;
    int roll;
    write_base(base);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        op = OP_ALLOC;
      end else if (roll < alloc_pct + (100 - alloc_pct) / 2) begin
        op = OP_FREE;
      end else begin
        op = $urandom_range(0, 1) ? OP_QUERY : OP_QUERY_HI;
      end
      send_request(op, pick_frame());
      // Now and then hold off until the block has answered everything.
      if ($urandom_range(0, 149) == 0) wait_results_done();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The bitmap clearing pass keeps tready low.
    do @(posedge clk_i); while (!s_axis_tready);

    test_directed_cases();
    test_fill_to_full();
    wait_results_done();
    test_random_mix(shadow_base, 20, 120);
    test_random_mix('0, 50, 110);
    test_random_mix(BASE_TOP, 45, 100);
    test_random_mix(FRAME_W'($urandom_range(0, BASE_TOP)), 30, 110);
    test_random_mix(FRAME_W'($urandom_range(1, 64)), 55, 100);

    wait_results_done();
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/bfa_pkg.sv
sv/bfa_bitmap_mem.sv
sv/bfa_engine.sv
sv/bitmap_frame_allocator_unit.sv
sv/bfa_checker.sv
bench/tb_bitmap_frame_allocator_unit.sv
